[sv/iss_pkg.sv]
`default_nettype none

package iss_pkg;

    // One input request: a value and the end-of-set mark.
    typedef struct packed {
        logic signed [31:0] value;
        logic               set_end;
    } req_t;

    // One emitted result.
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               run_end;
        logic               overflow;
    } res_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;   // place the key, shift larger values up by one
        logic drain;    // shift the whole chain down by one toward cell 0
    } cell_ctrl_t;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

endpackage

`default_nettype wire

[sv/iss_cell.sv]
`default_nettype none

module iss_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                          clk,
    input  wire iss_pkg::cell_ctrl_t     ctrl,
    input  wire logic signed [DATA_WIDTH-1:0] key,
    input  wire                          occ,
    input  wire                          prev_occ,
    input  wire                          prev_gt,
    input  wire logic signed [DATA_WIDTH-1:0] prev_val,
    input  wire logic signed [DATA_WIDTH-1:0] next_val,
    output logic                         gt,
    output logic signed [DATA_WIDTH-1:0] val
);

    logic signed [DATA_WIDTH-1:0] val_reg;
    logic signed [DATA_WIDTH-1:0] val_next;

    // Strictly greater keeps equal values in arrival order.
    assign gt  = occ && (val_reg > key);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.drain)
        begin
            val_next = next_val;
        end
        else if (ctrl.insert)
        begin
            priority if (prev_gt)
            begin
                val_next = prev_val;
            end
            else if (gt || (!occ && prev_occ))
            begin
                val_next = key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

[sv/insertion_sort_stream.sv]
`default_nettype none

// Channel  | Ports                     | Handshake
// ---------+---------------------------+-----------------------------------------
// request  | request (req_t)           | taken at an edge with start=1, busy=0
// result   | result (res_t)            | each result marked by strobe
//
// Each request is inserted in parallel: every cell compares its value with the
// key at once and holds, takes the key or takes its lower neighbor's value.
// A request with set_end then drains the chain through cell 0, one result per
// cycle with busy high, so a set of n stored values gives n results.
// Reset clears the fill count, the drop flag and the sequencer; cell contents
// are only read below the fill count. The receiver cannot stall results.

module insertion_sort_stream #(
    parameter int MAX_ITEMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    input  wire iss_pkg::req_t request,
    output logic           busy,
    output logic           strobe,
    output iss_pkg::res_t  result
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] ONE_CNT = CW'(1);

    iss_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic            dropped_reg, dropped_next;

    logic                         accept;
    logic                         full;
    iss_pkg::cell_ctrl_t          ctrl;
    logic signed [DATA_WIDTH-1:0] key;
    logic signed [DATA_WIDTH-1:0] head;

    logic                         occ  [MAX_ITEMS];
    logic                         gt   [MAX_ITEMS];
    logic signed [DATA_WIDTH-1:0] vals [MAX_ITEMS];

    assign busy   = (state_reg == iss_pkg::ST_EMIT);
    assign accept = start && !busy;
    assign full   = (fill_reg == MAX_CNT);

    // Insert only when there is room; drain while emitting.
    assign ctrl.insert = accept && !full;
    assign ctrl.drain  = busy;

    // Narrow or widen the 32-bit input to the cell width.
    generate
        if (DATA_WIDTH <= 32)
        begin : g_key_narrow
            assign key = request.value[DATA_WIDTH-1:0];
        end
        else
        begin : g_key_wide
            assign key = {{(DATA_WIDTH-32){request.value[31]}}, request.value};
        end
    endgenerate

    // Build the cell chain; cell 0 holds the smallest value.
    generate
        for (genvar i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            logic                         p_occ;
            logic                         p_gt;
            logic signed [DATA_WIDTH-1:0] p_val;
            logic signed [DATA_WIDTH-1:0] n_val;

            assign occ[i] = (CW'(i) < fill_reg);

            if (i == 0)
            begin : g_first
                assign p_occ = 1'b1;
                assign p_gt  = 1'b0;
                assign p_val = key;
            end
            else
            begin : g_rest
                assign p_occ = occ[i-1];
                assign p_gt  = gt[i-1];
                assign p_val = vals[i-1];
            end

            if (i == MAX_ITEMS - 1)
            begin : g_top
                assign n_val = vals[i];
            end
            else
            begin : g_mid
                assign n_val = vals[i+1];
            end

            iss_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .key      (key),
                .occ      (occ[i]),
                .prev_occ (p_occ),
                .prev_gt  (p_gt),
                .prev_val (p_val),
                .next_val (n_val),
                .gt       (gt[i]),
                .val      (vals[i])
            );
        end
    endgenerate

    assign head = vals[0];

    // Sign-extend or truncate the cell width back to the 32-bit field.
    generate
        if (DATA_WIDTH >= 32)
        begin : g_out_narrow
            assign result.sorted_value = head[31:0];
        end
        else
        begin : g_out_wide
            assign result.sorted_value = {{(32-DATA_WIDTH){head[DATA_WIDTH-1]}}, head};
        end
    endgenerate

    assign strobe          = busy;
    assign result.run_end  = (rem_reg == ONE_CNT);
    assign result.overflow = dropped_reg;

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        rem_next     = rem_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            iss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // Count the new value, or drop it and flag the set.
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + ONE_CNT;
                    end
                    if (request.set_end)
                    begin
                        rem_next   = fill_next;
                        state_next = iss_pkg::ST_EMIT;
                    end
                end
            end
            iss_pkg::ST_EMIT:
            begin
                // Advance one result per cycle; clear for the next set at the end.
                rem_next = rem_reg - ONE_CNT;
                if (rem_reg == ONE_CNT)
                begin
                    fill_next    = '0;
                    dropped_next = 1'b0;
                    state_next   = iss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= iss_pkg::ST_IDLE;
            fill_reg    <= '0;
            rem_reg     <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rem_reg     <= rem_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

`default_nettype wire

[sim/insertion_sort_stream_tb.sv]
`default_nettype none

module insertion_sort_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITEMS   = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int STALL_LIMIT = 2000;  // cycles with no request and no result
    localparam int DRAIN_WAIT  = 10;    // settle time once nothing is pending

    logic           clk;
    logic           rst_n;
    logic           start;
    iss_pkg::req_t  request;
    logic           busy;
    logic           strobe;
    iss_pkg::res_t  result;

    // Sorted copy of the current set, the drop flag for that set, and the
    // results still owed by the block, oldest first.
    logic signed [31:0] held_values[$];
    logic               held_dropped;
    iss_pkg::res_t      sorted_due[$];

    // Sender idling on or off; bookkeeping for the summary.
    bit gaps_on;
    int errors;
    int requests_sent;
    int results_seen;
    int sets_sent;
    int overflow_sets;
    int max_set_seen;
    int idle_cycles;

    insertion_sort_stream #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .strobe  (strobe),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Fold one accepted request into the sorted copy. A value moves past
    // stored values that are strictly greater, so ties keep arrival order.
    // A full store drops the value and marks the set. The set-end request
    // queues the whole set in ascending order and clears for the next set.
    task automatic absorb_request(input iss_pkg::req_t r);
        int            j;
        int            n;
        iss_pkg::res_t res;
        if (held_values.size() < MAX_ITEMS)
        begin
            j = held_values.size();
            while (j > 0 && held_values[j - 1] > r.value)
                j--;
            held_values.insert(j, r.value);
        end
        else
        begin
            held_dropped = 1'b1;
        end
        if (r.set_end)
        begin
            n = held_values.size();
            for (int k = 0; k < n; k++)
            begin
                res.sorted_value = held_values[k];
                res.run_end      = (k == n - 1);
                res.overflow     = held_dropped;
                sorted_due.push_back(res);
            end
            sets_sent++;
            if (held_dropped)
                overflow_sets++;
            if (n > max_set_seen)
                max_set_seen = n;
            held_values.delete();
            held_dropped = 1'b0;
        end
    endtask

    // Present one request at a falling edge and hold it until an edge with
    // busy low takes it. Idle cycles go in front, one start assignment per
    // falling edge, so start never drops and rises in the same step.
    task automatic send_request(input logic signed [31:0] v, input logic last);
        iss_pkg::req_t r;
        r.value   = v;
        r.set_end = last;
        @(negedge clk);
        while (gaps_on && $urandom_range(99, 0) < 22)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        requests_sent++;
        absorb_request(r);
    endtask

    // Drop start once the stimulus of a test is done.
    task automatic release_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Hold until every queued result has come out of the block.
    task automatic wait_sets_done();
        while (sorted_due.size() != 0)
            @(posedge clk);
    endtask

    // Random value: half full range, a quarter small values so ties occur,
    // the rest at or next to the extremes.
    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(7, 0);
        if (sel < 4)
            return $urandom;
        else if (sel < 6)
            return int'($urandom_range(16, 0)) - 8;
        else if (sel == 6)
            return 32'sh7FFF_FFFF - int'($urandom_range(2, 0));
        else
            return 32'sh8000_0000 + int'($urandom_range(2, 0));
    endfunction

    // Set of one: the lone result must carry the end mark.
    task automatic test_single_sets();
        send_request(32'sh7FFF_FFFF, 1'b1);
        send_request(32'sh8000_0000, 1'b1);
    endtask

    // Field extremes mixed together in one set.
    task automatic test_extremes();
        send_request(32'sh0000_0000, 1'b0);
        send_request(-32'sd1, 1'b0);
        send_request(32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh8000_0000, 1'b0);
        send_request(32'sd1, 1'b0);
        send_request(32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh8000_0000, 1'b0);
        send_request(32'sh8000_0001, 1'b0);
        send_request(32'sh7FFF_FFFE, 1'b1);
    endtask

    // Reverse order forces every insert to shift the whole chain; then ties.
    task automatic test_order_and_ties();
        for (int k = 5; k >= 1; k--)
            send_request(k, k == 1);
        send_request(32'sd3, 1'b0);
        send_request(32'sd3, 1'b0);
        send_request(-32'sd3, 1'b0);
        send_request(32'sd3, 1'b1);
    endtask

    // Random sets, mostly short, now and then a long one, until about
    // item_budget requests have gone in. Every set is closed.
    task automatic test_random_sets(input int item_budget);
        int left;
        int size;
        left = item_budget;
        while (left > 0)
        begin
            if ($urandom_range(9, 0) == 0)
                size = $urandom_range(40, 20);
            else
                size = $urandom_range(12, 1);
            if (size > left)
                size = left;
            for (int k = 0; k < size; k++)
                send_request(pick_value(), k == size - 1);
            left -= size;
        end
    endtask

    // Store full: one set that fills it exactly, then one that spills two
    // values, the second of them carrying the end mark.
    task automatic test_full_store();
        for (int k = 0; k < MAX_ITEMS; k++)
            send_request(pick_value(), k == MAX_ITEMS - 1);
        for (int k = 0; k < MAX_ITEMS + 2; k++)
            send_request(pick_value(), k == MAX_ITEMS + 1);
    endtask

    // Back-to-back requests with no idling at all.
    task automatic test_no_gaps();
        gaps_on = 1'b0;
        test_random_sets(30);
        gaps_on = 1'b1;
    endtask

    // Hold the sender until the block has emitted everything, then resume.
    task automatic test_pause_after_drain();
        for (int k = 0; k < 5; k++)
            send_request(pick_value(), k == 4);
        release_start();
        wait_sets_done();
        send_request(pick_value(), 1'b0);
        send_request(pick_value(), 1'b0);
        send_request(pick_value(), 1'b1);
    endtask

    // Compare each strobed result with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ($isunknown(strobe))
            begin
                errors++;
                $display("%0t: strobe unknown", $time);
            end
            else if (strobe)
            begin
                results_seen++;
                if (sorted_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no result, got %0d/%b/%b",
                             $time, result.sorted_value, result.run_end,
                             result.overflow);
                end
                else
                begin
                    if (result.sorted_value !== sorted_due[0].sorted_value ||
                        result.run_end !== sorted_due[0].run_end ||
                        result.overflow !== sorted_due[0].overflow)
                    begin
                        errors++;
                        $display("%0t: expected %0d/%b/%b, got %0d/%b/%b",
                                 $time, sorted_due[0].sorted_value,
                                 sorted_due[0].run_end, sorted_due[0].overflow,
                                 result.sorted_value, result.run_end,
                                 result.overflow);
                    end
                    void'(sorted_due.pop_front());
                end
            end
        end
    end

    // Count cycles in which neither a request nor a result moves; end the
    // run if the block stops making progress.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((start && busy === 1'b0) || strobe === 1'b1)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        held_dropped = 1'b0;
        gaps_on      = 1'b1;
        errors       = 0;
        requests_sent = 0;
        results_seen  = 0;
        sets_sent     = 0;
        overflow_sets = 0;
        max_set_seen  = 0;

        // Hold reset, then release it away from the rising edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_sets();
        test_extremes();
        test_order_and_ties();
        test_random_sets(60);
        test_full_store();
        test_no_gaps();
        test_pause_after_drain();
        test_random_sets(40);

        // Drop start, let the last set drain, then watch for strays.
        release_start();
        wait_sets_done();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d requests in %0d sets (largest %0d, %0d with overflow),",
                 requests_sent, sets_sent, max_set_seen, overflow_sets);
        $display("checked %0d sorted results, %0d errors.", results_seen, errors);
        if (errors == 0 && sorted_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
